/* rtl/rmq_pkg.sv */
// rmq_pkg: payload types, path codes and width helpers for the
// rotation matrix to quaternion pipeline. No dependencies.
package rmq_pkg;

  localparam int FRAC_BITS_DEF = 14;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } rmq_in_t;

  typedef struct packed {
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic [1:0]         path_taken;
    logic               invalid;
  } rmq_out_t;

  typedef enum logic [1:0] {
    PATH_TRACE = 2'd0,
    PATH_X     = 2'd1,
    PATH_Y     = 2'd2,
    PATH_Z     = 2'd3
  } path_e;

  // travels alongside the square root
  typedef struct packed {
    path_e              path;
    logic               bad;
    logic signed [16:0] n0;
    logic signed [16:0] n1;
    logic signed [16:0] n2;
  } sq_side_t;

  // signed width of the radicand
  function automatic int rad_w(input int f);
    return ((f + 2 > 18) ? f + 2 : 18) + 2;
  endfunction

  // square-root argument width, rounded up to even
  function automatic int sq_w(input int f);
    int aw;
    aw = rad_w(f) - 1 + f + 2;
    return aw + (aw % 2);
  endfunction

  function automatic int root_w(input int f);
    return sq_w(f) / 2;
  endfunction

  // dividend width: 17-bit magnitude shifted by f, plus a carry
  function automatic int num_w(input int f);
    return f + 18;
  endfunction

endpackage

/* rtl/rmq_front.sv */
// rmq_front: path choice, radicand and numerator selection, one register stage.
// Depends on rmq_pkg.
module rmq_front import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  rmq_in_t                     mat_i,
  output logic                        valid_o,
  output logic [sq_w(FRAC_BITS)-1:0]  arg_o,
  output sq_side_t                    side_o
);

  localparam int RW   = rad_w(FRAC_BITS);
  localparam int RADW = RW - 1;
  localparam int SW   = sq_w(FRAC_BITS);
  localparam int ONE  = 1 << FRAC_BITS;

  logic signed [RW-1:0] e00, e11, e22, one_s, tr, rad;
  logic signed [16:0]   dx, dy, dz, s01, s02, s12;
  path_e                path;
  logic                 bad;
  sq_side_t             side_d, side_q;
  logic [SW-1:0]        arg_d, arg_q;
  logic                 valid_q;

  always_comb begin
    e00   = RW'(mat_i.m00);
    e11   = RW'(mat_i.m11);
    e22   = RW'(mat_i.m22);
    one_s = RW'(ONE);
    tr    = e00 + e11 + e22 + one_s;
    dx    = 17'(mat_i.m12) - 17'(mat_i.m21);
    dy    = 17'(mat_i.m20) - 17'(mat_i.m02);
    dz    = 17'(mat_i.m01) - 17'(mat_i.m10);
    s01   = 17'(mat_i.m10) + 17'(mat_i.m01);
    s02   = 17'(mat_i.m20) + 17'(mat_i.m02);
    s12   = 17'(mat_i.m21) + 17'(mat_i.m12);
    if (tr > 0) begin
      path = PATH_TRACE;
    end else if (mat_i.m11 > mat_i.m00) begin
      path = (mat_i.m22 > mat_i.m11) ? PATH_Z : PATH_Y;
    end else begin
      path = (mat_i.m22 > mat_i.m00) ? PATH_Z : PATH_X;
    end
    unique case (path)
      PATH_TRACE: begin
        rad = tr;
        side_d.n0 = dx; side_d.n1 = dy; side_d.n2 = dz;
      end
      PATH_X: begin
        rad = one_s + e00 - e11 - e22;
        side_d.n0 = s01; side_d.n1 = s02; side_d.n2 = dx;
      end
      PATH_Y: begin
        rad = one_s - e00 + e11 - e22;
        side_d.n0 = s01; side_d.n1 = s12; side_d.n2 = dy;
      end
      default: begin
        rad = one_s - e00 - e11 + e22;
        side_d.n0 = s02; side_d.n1 = s12; side_d.n2 = dz;
      end
    endcase
    bad         = !(rad > 0);
    side_d.path = path;
    side_d.bad  = bad;
    arg_d = bad ? '0 : SW'({rad[RADW-1:0], {(FRAC_BITS + 2){1'b0}}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    arg_q  <= arg_d;
    side_q <= side_d;
  end

  assign valid_o = valid_q;
  assign arg_o   = arg_q;
  assign side_o  = side_q;

endmodule

/* rtl/rmq_sqrt.sv */
// rmq_sqrt: pipelined integer square root, one root bit per stage.
// Depends on rmq_pkg.
module rmq_sqrt import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [sq_w(FRAC_BITS)-1:0]   arg_i,
  input  sq_side_t                     side_i,
  output logic                         valid_o,
  output logic [root_w(FRAC_BITS)-1:0] root_o,
  output sq_side_t                     side_o
);

  localparam int SW = sq_w(FRAC_BITS);
  localparam int DW = root_w(FRAC_BITS);

  logic [SW-1:0] rem_q  [DW];
  logic [SW-1:0] root_q [DW];
  logic          v_q    [DW];
  sq_side_t      sd_q   [DW];

  for (genvar g = 0; g < DW; g++) begin : g_stage
    localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2 * g);
    logic [SW-1:0] rem_in, root_in, trial;
    logic          v_in, ge;
    sq_side_t      sd_in;

    if (g == 0) begin : g_first
      assign rem_in  = arg_i;
      assign root_in = '0;
      assign v_in    = valid_i;
      assign sd_in   = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign v_in    = v_q[g-1];
      assign sd_in   = sd_q[g-1];
    end

    assign trial = root_in + BIT;
    assign ge    = rem_in >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g]  <= ge ? rem_in - trial : rem_in;
      root_q[g] <= ge ? (root_in >> 1) + BIT : root_in >> 1;
      sd_q[g]   <= sd_in;
    end
  end

  assign valid_o = v_q[DW-1];
  assign root_o  = root_q[DW-1][DW-1:0];
  assign side_o  = sd_q[DW-1];

endmodule

/* rtl/rmq_div.sv */
// rmq_div: pipelined restoring divider, one quotient bit per stage,
// with a sideband that moves in step. No dependencies.
module rmq_div #(
  parameter int NW  = 32,
  parameter int DW  = 18,
  parameter int SBW = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [NW-1:0]  num_i,
  input  logic [DW-1:0]  den_i,
  input  logic [SBW-1:0] side_i,
  output logic           valid_o,
  output logic [NW-1:0]  quo_o,
  output logic [SBW-1:0] side_o
);

  logic [DW-1:0]  rem_q [NW];
  logic [NW-1:0]  num_q [NW];
  logic [NW-1:0]  quo_q [NW];
  logic [DW-1:0]  den_q [NW];
  logic [SBW-1:0] sd_q  [NW];
  logic           v_q   [NW];

  for (genvar g = 0; g < NW; g++) begin : g_stage
    logic [DW-1:0]  rem_in, den_in;
    logic [NW-1:0]  num_in, quo_in;
    logic [SBW-1:0] sd_in;
    logic           v_in, ge;
    logic [DW:0]    rt, diff;

    if (g == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
      assign sd_in  = side_i;
      assign v_in   = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign num_in = num_q[g-1];
      assign quo_in = quo_q[g-1];
      assign den_in = den_q[g-1];
      assign sd_in  = sd_q[g-1];
      assign v_in   = v_q[g-1];
    end

    assign rt   = {rem_in, num_in[NW-1]};
    assign diff = rt - {1'b0, den_in};
    assign ge   = rt >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g] <= ge ? diff[DW-1:0] : rt[DW-1:0];
      num_q[g] <= num_in << 1;
      quo_q[g] <= {quo_in[NW-2:0], ge};
      den_q[g] <= den_in;
      sd_q[g]  <= sd_in;
    end
  end

  assign valid_o = v_q[NW-1];
  assign quo_o   = quo_q[NW-1];
  assign side_o  = sd_q[NW-1];

endmodule

/* rtl/rmq_back.sv */
// rmq_back: saturation, component placement and the result register.
// Depends on rmq_pkg.
module rmq_back import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  path_e                       path_i,
  input  logic                        bad_i,
  input  logic [root_w(FRAC_BITS):0]  main_i,
  input  logic [2:0]                  neg_i,
  input  logic [num_w(FRAC_BITS)-1:0] quo0_i,
  input  logic [num_w(FRAC_BITS)-1:0] quo1_i,
  input  logic [num_w(FRAC_BITS)-1:0] quo2_i,
  output logic                        done_o,
  output rmq_out_t                    res_o
);

  localparam int NW   = num_w(FRAC_BITS);
  localparam int ONE  = 1 << FRAC_BITS;
  localparam int LIMP = (ONE < 32767) ? ONE : 32767;
  localparam int LIMN = (ONE < 32768) ? ONE : 32768;

  function automatic logic [15:0] sat16(input logic neg, input logic [NW-1:0] mag);
    logic [NW-1:0] lim, m;
    logic [16:0]   v;
    lim = neg ? NW'(LIMN) : NW'(LIMP);
    m   = (mag > lim) ? lim : mag;
    v   = m[16:0];
    v   = neg ? -v : v;
    return v[15:0];
  endfunction

  logic [15:0] c0, c1, c2, cm;
  rmq_out_t    res_d, res_q;
  logic        done_q;

  always_comb begin
    c0 = sat16(neg_i[0], quo0_i);
    c1 = sat16(neg_i[1], quo1_i);
    c2 = sat16(neg_i[2], quo2_i);
    cm = sat16(1'b0, NW'(main_i));
    unique case (path_i)
      PATH_TRACE: begin
        res_d.qx = c0; res_d.qy = c1; res_d.qz = c2; res_d.qw = cm;
      end
      PATH_X: begin
        res_d.qx = cm; res_d.qy = c0; res_d.qz = c1; res_d.qw = c2;
      end
      PATH_Y: begin
        res_d.qx = c0; res_d.qy = cm; res_d.qz = c1; res_d.qw = c2;
      end
      default: begin
        res_d.qx = c0; res_d.qy = c1; res_d.qz = cm; res_d.qw = c2;
      end
    endcase
    if (bad_i) begin
      res_d.qx = '0; res_d.qy = '0; res_d.qz = '0; res_d.qw = '0;
    end
    res_d.path_taken = path_i;
    res_d.invalid    = bad_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* rtl/rotation_matrix_to_quaternion.sv */
// rotation_matrix_to_quaternion: top level of the pipelined converter.
// Depends on rmq_pkg, rmq_front, rmq_sqrt, rmq_div, rmq_back.
//
//   channel   ports                 transfer when
//   input     start, busy, mat_i    start high and busy low at a clock edge
//   result    done_o, res_o         done_o high at a clock edge
//
// One matrix can enter every cycle; busy is always low.
// The pipeline has one front stage, one stage per root bit in the square root,
// one numerator stage, one stage per quotient bit in the three parallel
// dividers and one output stage.
// Reset clears only the valid bits; results cannot be held off.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  rmq_in_t  mat_i,
  output logic     done_o,
  output rmq_out_t res_o
);

  localparam int SW  = sq_w(FRAC_BITS);
  localparam int DW  = root_w(FRAC_BITS);
  localparam int NW  = num_w(FRAC_BITS);
  localparam int SBW = DW + 5;

  logic          f_valid, s_valid;
  logic [SW-1:0] f_arg;
  sq_side_t      f_side, s_side;
  logic [DW-1:0] s_root;

  assign busy = 1'b0;

  rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i, .rst_ni,
    .valid_i (start),
    .mat_i,
    .valid_o (f_valid),
    .arg_o   (f_arg),
    .side_o  (f_side)
  );

  rmq_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk_i, .rst_ni,
    .valid_i (f_valid),
    .arg_i   (f_arg),
    .side_i  (f_side),
    .valid_o (s_valid),
    .root_o  (s_root),
    .side_o  (s_side)
  );

  // numerator stage: magnitude * ONE plus half the divisor for rounding
  logic signed [16:0] n [3];
  logic [16:0]        mag [3];
  logic [NW-1:0]      num_d [3];
  logic [NW-1:0]      num_q [3];
  logic [2:0]         neg_d, neg_q;
  logic [DW:0]        main_d, main_q;
  logic [DW-1:0]      den_q;
  path_e              path_q;
  logic               bad_q, p_valid_q;

  always_comb begin
    n[0] = s_side.n0;
    n[1] = s_side.n1;
    n[2] = s_side.n2;
    for (int k = 0; k < 3; k++) begin
      neg_d[k] = n[k] < 0;
      mag[k]   = neg_d[k] ? 17'(-n[k]) : 17'(n[k]);
      num_d[k] = NW'({mag[k], {FRAC_BITS{1'b0}}}) + NW'(s_root >> 1);
    end
    main_d = ((DW + 1)'(s_root) + (DW + 1)'(2)) >> 2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= s_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    neg_q  <= neg_d;
    main_q <= main_d;
    den_q  <= s_root;
    path_q <= s_side.path;
    bad_q  <= s_side.bad;
  end

  logic           d_valid, d_unused1, d_unused2;
  logic [NW-1:0]  quo [3];
  logic [SBW-1:0] sb_in, sb_out;
  logic [0:0]     neg1_o, neg2_o;
  logic [1:0]     d_path_bits;
  path_e          d_path;
  logic           d_bad, d_neg0;
  logic [DW:0]    d_main;

  assign sb_in = {path_q, bad_q, main_q, neg_q[0]};

  rmq_div #(.NW(NW), .DW(DW), .SBW(SBW)) u_div0 (
    .clk_i, .rst_ni,
    .valid_i (p_valid_q),
    .num_i   (num_q[0]),
    .den_i   (den_q),
    .side_i  (sb_in),
    .valid_o (d_valid),
    .quo_o   (quo[0]),
    .side_o  (sb_out)
  );

  rmq_div #(.NW(NW), .DW(DW), .SBW(1)) u_div1 (
    .clk_i, .rst_ni,
    .valid_i (p_valid_q),
    .num_i   (num_q[1]),
    .den_i   (den_q),
    .side_i  (neg_q[1]),
    .valid_o (d_unused1),
    .quo_o   (quo[1]),
    .side_o  (neg1_o)
  );

  rmq_div #(.NW(NW), .DW(DW), .SBW(1)) u_div2 (
    .clk_i, .rst_ni,
    .valid_i (p_valid_q),
    .num_i   (num_q[2]),
    .den_i   (den_q),
    .side_i  (neg_q[2]),
    .valid_o (d_unused2),
    .quo_o   (quo[2]),
    .side_o  (neg2_o)
  );

  assign {d_path_bits, d_bad, d_main, d_neg0} = sb_out;
  assign d_path = path_e'(d_path_bits);

  // all three dividers run in lockstep
  rmq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .valid_i (d_valid & d_unused1 & d_unused2),
    .path_i  (d_path),
    .bad_i   (d_bad),
    .main_i  (d_main),
    .neg_i   ({neg2_o, neg1_o, d_neg0}),
    .quo0_i  (quo[0]),
    .quo1_i  (quo[1]),
    .quo2_i  (quo[2]),
    .done_o,
    .res_o
  );

endmodule

/* dv/tb.sv */
// tb: self-checking testbench for rotation_matrix_to_quaternion.
// Computes each expected quaternion in an in-bench fixed-point model and checks results in order.
// Depends on rmq_pkg and the rotation_matrix_to_quaternion RTL.
`timescale 1ns / 1ps

module tb;
  import rmq_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) << FB;
  localparam int LATENCY = 53;
  localparam int CYCLE_LIMIT = 400000;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  rmq_in_t  mat_i;
  logic     done_o;
  rmq_out_t res_o;

  rmq_out_t quat_q[$];
  int       fail_cnt;
  int       sent_cnt;
  int       got_cnt;
  int       path_cnt[4];
  int       cycle_cnt;
  bit       no_gaps;

  rotation_matrix_to_quaternion u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .mat_i (mat_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned rem, root, b;
    rem = v;
    root = 0;
    b = longint'(1) << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // num * ONE / d, rounded half away from zero
  function automatic longint ratio_round(longint num, longint unsigned d);
    longint unsigned mag, q;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = ((mag << FB) + (d >> 1)) / d;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [15:0] clamp_q(longint v);
    if (v > ONE) v = ONE;
    if (v < -ONE) v = -ONE;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic rmq_out_t quat_of(rmq_in_t m);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, rad, best, main_c;
    longint q[4];
    longint unsigned d;
    path_e p;
    rmq_out_t r;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    q = '{0, 0, 0, 0};
    if (a00 + a11 + a22 + ONE > 0) begin
      p = PATH_TRACE;
      rad = a00 + a11 + a22 + ONE;
    end else begin
      // ties keep the earlier diagonal entry
      best = a00;
      p = PATH_X;
      if (a11 > best) begin
        best = a11;
        p = PATH_Y;
      end
      if (a22 > best) p = PATH_Z;
      case (p)
        PATH_X:  rad = ONE + a00 - a11 - a22;
        PATH_Y:  rad = ONE - a00 + a11 - a22;
        default: rad = ONE - a00 - a11 + a22;
      endcase
    end
    r.invalid = (rad <= 0);
    if (rad > 0) begin
      d = root_floor(longint'(rad) << (FB + 2));
      main_c = longint'((d + 2) >> 2);
      if (d == 0) d = 1;
      case (p)
        PATH_TRACE: begin
          q[0] = ratio_round(a12 - a21, d);
          q[1] = ratio_round(a20 - a02, d);
          q[2] = ratio_round(a01 - a10, d);
          q[3] = main_c;
        end
        PATH_X: begin
          q[0] = main_c;
          q[1] = ratio_round(a10 + a01, d);
          q[2] = ratio_round(a20 + a02, d);
          q[3] = ratio_round(a12 - a21, d);
        end
        PATH_Y: begin
          q[0] = ratio_round(a10 + a01, d);
          q[1] = main_c;
          q[2] = ratio_round(a21 + a12, d);
          q[3] = ratio_round(a20 - a02, d);
        end
        default: begin
          q[0] = ratio_round(a20 + a02, d);
          q[1] = ratio_round(a21 + a12, d);
          q[2] = main_c;
          q[3] = ratio_round(a01 - a10, d);
        end
      endcase
    end
    r.qx = clamp_q(q[0]);
    r.qy = clamp_q(q[1]);
    r.qz = clamp_q(q[2]);
    r.qw = clamp_q(q[3]);
    r.path_taken = p;
    return r;
  endfunction

  // expectation on each input transfer, check on each result strobe
  always @(posedge clk_i) begin
    rmq_out_t want;
    if (rst_ni) begin
      cycle_cnt <= cycle_cnt + 1;
      if (start && !busy) quat_q.push_back(quat_of(mat_i));
      if (done_o) begin
        got_cnt <= got_cnt + 1;
        if (quat_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, res_o);
          fail_cnt <= fail_cnt + 1;
        end else begin
          want = quat_q.pop_front();
          path_cnt[want.path_taken] <= path_cnt[want.path_taken] + 1;
          if (res_o.qx !== want.qx)
            $display("%0t: qx exp %0d got %0d", $time, want.qx, res_o.qx);
          if (res_o.qy !== want.qy)
            $display("%0t: qy exp %0d got %0d", $time, want.qy, res_o.qy);
          if (res_o.qz !== want.qz)
            $display("%0t: qz exp %0d got %0d", $time, want.qz, res_o.qz);
          if (res_o.qw !== want.qw)
            $display("%0t: qw exp %0d got %0d", $time, want.qw, res_o.qw);
          if (res_o.path_taken !== want.path_taken)
            $display("%0t: path exp %0d got %0d", $time, want.path_taken,
                     res_o.path_taken);
          if (res_o.invalid !== want.invalid)
            $display("%0t: invalid exp %0b got %0b", $time, want.invalid,
                     res_o.invalid);
          if (res_o !== want) fail_cnt <= fail_cnt + 1;
        end
      end
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_cnt);
        $display("** rotation_matrix_to_quaternion: FAILED **");
        $finish;
      end
    end
  end

  // an idle gap before about one item in five, unless no_gaps is set
  task automatic send_mat(rmq_in_t m);
    if (!no_gaps && $urandom_range(0, 99) < 20) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    mat_i <= m;
    do @(posedge clk_i); while (busy);
    sent_cnt++;
  endtask

  function automatic rmq_in_t mat_of(int e[9]);
    rmq_in_t m;
    m.m00 = 16'(e[0]); m.m01 = 16'(e[1]); m.m02 = 16'(e[2]);
    m.m10 = 16'(e[3]); m.m11 = 16'(e[4]); m.m12 = 16'(e[5]);
    m.m20 = 16'(e[6]); m.m21 = 16'(e[7]); m.m22 = 16'(e[8]);
    return m;
  endfunction

  function automatic int unit_val();
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  task automatic test_directed();
    localparam int P = 16384;
    localparam int N = -16384;
    send_mat(mat_of('{P, 0, 0, 0, P, 0, 0, 0, P}));
    send_mat(mat_of('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
    send_mat(mat_of('{P, 0, 0, 0, N, 0, 0, 0, N}));
    send_mat(mat_of('{N, 0, 0, 0, P, 0, 0, 0, N}));
    send_mat(mat_of('{N, 0, 0, 0, N, 0, 0, 0, P}));
    // tie cases on the diagonal
    send_mat(mat_of('{N, 0, 0, 0, N, 0, 0, 0, N}));
    send_mat(mat_of('{-20000, 100, 200, 300, -8000, 400, 500, 600, -8000}));
    send_mat(mat_of('{-8000, 100, 200, 300, -8000, 400, 500, 600, -20000}));
    send_mat(mat_of('{0, N, 0, P, 0, 0, 0, 0, P}));
    send_mat(mat_of('{0, P, 0, N, 0, 0, 0, 0, P}));
    send_mat(mat_of('{P, P, P, P, P, P, P, P, P}));
    send_mat(mat_of('{N, N, N, N, N, N, N, N, N}));
    send_mat(mat_of('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}));
    send_mat(mat_of('{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                      -32768}));
    // extreme entries, including saturation
    send_mat(mat_of('{N, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0}));
    send_mat(mat_of('{-16383, 32767, 32767, 32767, -16384, -32768, -32768, 32767, 0}));
    send_mat(mat_of('{32767, 32767, -32768, 32767, -32768, 32767, -32768, -32768,
                      -32768}));
    send_mat(mat_of('{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768}));
    send_mat(mat_of('{11585, -11585, 0, 11585, 11585, 0, 0, 0, P}));
  endtask

  task automatic test_random(int count, bit trace_neg);
    int e[9];
    int dom, mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(0, 9);
      for (int k = 0; k < 9; k++)
        e[k] = (mode < 2) ? int'($urandom_range(0, 65535)) - 32768 : unit_val();
      if (trace_neg && mode >= 2) begin
        // pick one diagonal to dominate, push the others down; mode 9 copies it to the next diagonal for a tie
        dom = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++)
          if (k != dom) e[4 * k] = -int'($urandom_range(8192, 32768));
        if (mode == 9) e[4 * ((dom + 1) % 3)] = e[4 * dom];
      end
      send_mat(mat_of(e));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    mat_i = '0;
    fail_cnt = 0;
    sent_cnt = 0;
    got_cnt = 0;
    cycle_cnt = 0;
    no_gaps = 1'b0;
    path_cnt = '{0, 0, 0, 0};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(700, 1'b0);
    no_gaps = 1'b1;
    test_random(400, 1'b1);
    no_gaps = 1'b0;
    test_random(830, 1'b1);
    start <= 1'b0;
    while (quat_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("sent %0d matrices, checked %0d results", sent_cnt, got_cnt);
    $display("paths: trace %0d, x %0d, y %0d, z %0d", path_cnt[0], path_cnt[1],
             path_cnt[2], path_cnt[3]);
    if (fail_cnt == 0 && quat_q.size() == 0) begin
      $display("** rotation_matrix_to_quaternion: PASSED **");
    end else begin
      $display("** rotation_matrix_to_quaternion: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/rmq_pkg.sv
rtl/rmq_front.sv
rtl/rmq_sqrt.sv
rtl/rmq_div.sv
rtl/rmq_back.sv
rtl/rotation_matrix_to_quaternion.sv
dv/tb.sv
